// ===== design/cst_pkg.sv =====
`timescale 1ns / 1ps

package cst_pkg;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint INV_TWO_PI_Q32 = 64'sd683565276;
	localparam longint PI_Q16_X1000 = 64'sd205887000;

	localparam int DIV_W = 27;
	localparam int REM_W = 14;

	typedef enum logic [0:0] {
		REG_STEP_HEIGHT = 1'b0,
		REG_SWING_PERIOD = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [DIV_W-1:0] num;
		logic [REM_W-1:0] rem;
	} div_lane_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_z;
		logic neg_x;
		logic neg_z;
		div_lane_t lane_x;
		div_lane_t lane_z;
	} div_t;

	function automatic div_lane_t div_step(input div_lane_t l, input logic [REM_W-1:0] d);
		logic [REM_W:0] r;
		div_lane_t o;
		r = {l.rem, l.num[DIV_W-1]};
		if (r >= {1'b0, d}) begin
			o.rem = REM_W'(r - {1'b0, d});
			o.num = {l.num[DIV_W-2:0], 1'b1};
		end else begin
			o.rem = REM_W'(r);
			o.num = {l.num[DIV_W-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic signed [15:0] turn_sine(input logic [31:0] u);
		longint sv;
		longint m;
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint r;
		logic neg;
		sv = longint'(signed'(u));
		if (sv > 64'sd1073741824)
			sv = 64'sd2147483648 - sv;
		else if (sv < -64'sd1073741824)
			sv = -64'sd2147483648 - sv;
		neg = sv < 0;
		m = neg ? -sv : sv;
		x = (m * HALF_PI_Q30) >>> 30;
		x2 = (x * x) >>> 30;
		sum = x;
		term = x;
		for (int n = 1; n <= 6; n++) begin
			term = (term * x2) >>> 30;
			case (n)
				1: term = term / 6;
				2: term = term / 20;
				3: term = term / 42;
				4: term = term / 72;
				5: term = term / 110;
				default: term = term / 156;
			endcase
			if (n % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		if (sum < 0)
			sum = 0;
		r = (sum + 32768) >>> 16;
		if (r > 16384)
			r = 16384;
		return neg ? 16'(-r) : 16'(r);
	endfunction

endpackage

// ===== design/cst_if.sv =====
`timescale 1ns / 1ps

interface cst_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] start_x;
	logic signed [15:0] end_x;
	logic signed [15:0] start_z;
	logic [15:0] phase;
	modport source(output valid, start_x, end_x, start_z, phase, input ready);
	modport sink(input valid, start_x, end_x, start_z, phase, output ready);
endinterface

interface cst_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_z;
	logic signed [23:0] vel_x;
	logic signed [23:0] vel_z;
	modport source(output valid, pos_x, pos_z, vel_x, vel_z, input ready);
	modport sink(input valid, pos_x, pos_z, vel_x, vel_z, output ready);
endinterface

interface cst_cfg_if;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== design/cst_front.sv =====
`timescale 1ns / 1ps

module cst_front import cst_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int POSITION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input logic signed [15:0] start_x,
	input logic signed [15:0] end_x,
	input logic signed [15:0] start_z,
	input logic [15:0] phase,
	input logic [12:0] step_height,
	input logic [13:0] tms,
	output logic vld_out,
	output div_t item_out
);

	localparam int KW = $clog2(SINE_TABLE_DEPTH);
	localparam longint POS_HI = (64'sd1 <<< (POSITION_BITS - 1)) - 1;
	localparam longint POS_LO = -POS_HI - 1;

	function automatic logic signed [15:0] sat_pos(input longint v);
		if (v > POS_HI)
			return 16'(POS_HI);
		if (v < POS_LO)
			return 16'(POS_LO);
		return 16'(v);
	endfunction

	logic signed [15:0] sin_rom [SINE_TABLE_DEPTH];
	logic signed [15:0] cos_rom [SINE_TABLE_DEPTH];

	for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
		localparam logic [31:0] U = 32'((64'(i) << 32) / SINE_TABLE_DEPTH);
		assign sin_rom[i] = turn_sine(U);
		assign cos_rom[i] = turn_sine(U + 32'h4000_0000);
	end

	logic [31:0] kprod;
	logic [KW-1:0] k;
	assign kprod = 32'(phase) * 32'(SINE_TABLE_DEPTH);
	assign k = KW'(kprod >> 16);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [15:0] sx_s1, sz_s1, sn_s1, cs_s1;
	logic signed [16:0] dx_s1;
	logic [15:0] p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= start_x;
			sz_s1 <= start_z;
			dx_s1 <= 17'(end_x) - 17'(start_x);
			p_s1 <= phase;
			sn_s1 <= sin_rom[k];
			cs_s1 <= cos_rom[k];
		end
	end

	logic signed [15:0] sx_s2, sz_s2;
	logic signed [16:0] dx_s2;
	logic signed [47:0] g_s2;
	logic [27:0] hz_s2;
	logic signed [33:0] vxa_s2;
	logic signed [29:0] hs_s2;
	logic [15:0] omc;
	assign omc = 16'(17'sd16384 - 17'(cs_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2 <= sx_s1;
			sz_s2 <= sz_s1;
			dx_s2 <= dx_s1;
			g_s2 <= $signed({2'b00, p_s1, 30'd0})
				- 48'(48'(sn_s1) * 48'(INV_TWO_PI_Q32));
			hz_s2 <= 28'(step_height * omc);
			vxa_s2 <= 34'(dx_s1) * 34'($signed({1'b0, omc}));
			hs_s2 <= 30'($signed({1'b0, step_height})) * 30'(sn_s1);
		end
	end

	logic signed [15:0] sx_s3, pz_s3;
	logic signed [40:0] plo_s3;
	logic signed [41:0] phi_s3;
	logic signed [44:0] vxn_s3;
	logic signed [58:0] vzn_s3;
	logic [28:0] hz_r;
	assign hz_r = 29'(hz_s2) + 29'd16384;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s3 <= sx_s2;
			pz_s3 <= sat_pos(longint'(sz_s2) + longint'(hz_r[28:15]));
			plo_s3 <= 41'(dx_s2) * 41'($signed({1'b0, g_s2[22:0]}));
			phi_s3 <= 42'(dx_s2) * 42'($signed(g_s2[47:23]));
			vxn_s3 <= 45'(vxa_s2) * 45'sd1000;
			vzn_s3 <= 59'(hs_s2) * 59'(PI_Q16_X1000);
		end
	end

	logic signed [15:0] sx_s4, pz_s4;
	logic signed [63:0] prod_s4;
	logic neg_x_s4, neg_z_s4;
	logic [DIV_W-1:0] nx_s4, nz_s4;
	logic [44:0] vxm;
	logic [58:0] vzm;
	logic [45:0] vx_sum;
	logic [59:0] vz_sum;
	assign vxm = vxn_s3[44] ? 45'(-vxn_s3) : 45'(vxn_s3);
	assign vzm = vzn_s3[58] ? 59'(-vzn_s3) : 59'(vzn_s3);
	assign vx_sum = 46'(vxm) + (46'(tms) << 13);
	assign vz_sum = 60'(vzm) + (60'(tms) << 29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s4 <= sx_s3;
			pz_s4 <= pz_s3;
			prod_s4 <= 64'((65'(phi_s3) <<< 23) + 65'(plo_s3));
			neg_x_s4 <= vxn_s3[44];
			neg_z_s4 <= vzn_s3[58];
			nx_s4 <= vx_sum[DIV_W+13:14];
			nz_s4 <= vz_sum[DIV_W+29:30];
		end
	end

	logic [63:0] pm;
	logic [63:0] pm_r;
	logic [17:0] pq;
	logic signed [19:0] px;
	assign pm = prod_s4[63] ? 64'(-prod_s4) : 64'(prod_s4);
	assign pm_r = pm + (64'd1 << 45);
	assign pq = pm_r[63:46];
	assign px = prod_s4[63] ? 20'(sx_s4) - 20'(pq) : 20'(sx_s4) + 20'(pq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_out.pos_x <= sat_pos(longint'(px));
			item_out.pos_z <= pz_s4;
			item_out.neg_x <= neg_x_s4;
			item_out.neg_z <= neg_z_s4;
			item_out.lane_x <= '{num: nx_s4, rem: '0};
			item_out.lane_z <= '{num: nz_s4, rem: '0};
		end
	end

	assign vld_out = v_s5;

endmodule

// ===== design/cst_div.sv =====
`timescale 1ns / 1ps

module cst_div import cst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [REM_W-1:0] divisor,
	input logic vld_in,
	input div_t item_in,
	output logic vld_out,
	output div_t item_out
);

	logic vld_s [DIV_W+1];
	div_t item_s [DIV_W+1];

	assign vld_s[0] = vld_in;
	assign item_s[0] = item_in;

	for (genvar i = 0; i < DIV_W; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[i+1].pos_x <= item_s[i].pos_x;
				item_s[i+1].pos_z <= item_s[i].pos_z;
				item_s[i+1].neg_x <= item_s[i].neg_x;
				item_s[i+1].neg_z <= item_s[i].neg_z;
				item_s[i+1].lane_x <= div_step(item_s[i].lane_x, divisor);
				item_s[i+1].lane_z <= div_step(item_s[i].lane_z, divisor);
			end
		end
	end

	assign vld_out = vld_s[DIV_W];
	assign item_out = item_s[DIV_W];

endmodule

// ===== design/cycloid_swing_trajectory.sv =====
`timescale 1ns / 1ps
// Cycloid swing-foot trajectory point generator.
// req carries one swing sample per beat: start_x, end_x, start_z (Q3.12 m)
// and phase (fraction of the swing, /65536). rsp returns one beat per
// request with pos_x, pos_z (Q3.12 m) and vel_x, vel_z (Q11.12 m/s),
// all saturated, in request order.
// cfg writes step_height (index 0) and swing_period_ms (index 1); it is
// always ready. Write it only while no request is in flight.
// The path from request beat to response valid has five arithmetic
// stages, a 27-stage restoring divider by the swing period and one output
// register. Throughput: one beat per cycle while rsp is not stalled.
// When rsp stalls, the whole pipeline holds and req.ready drops; it
// returns as soon as the held response is taken.
// Reset clears all valid bits and loads step_height 328, period 250 ms.
module cycloid_swing_trajectory import cst_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int POSITION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	cst_in_if.sink req,
	cst_out_if.source rsp,
	cst_cfg_if.sink cfg
);

	logic [12:0] step_height_q;
	logic [13:0] swing_period_q;
	logic [13:0] tms;
	logic en;
	logic out_v_q;
	logic front_v, div_v;
	div_t front_item, div_item;
	logic [DIV_W-1:0] qx, qz;

	assign cfg.ready = 1'b1;
	assign tms = (swing_period_q == '0) ? 14'd1 : swing_period_q;
	assign en = !out_v_q || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_height_q <= 13'd328;
			swing_period_q <= 14'd250;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_STEP_HEIGHT: step_height_q <= cfg.data[12:0];
				REG_SWING_PERIOD: swing_period_q <= cfg.data[13:0];
				default: ;
			endcase
		end
	end

	cst_front #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_in(req.valid),
		.start_x(req.start_x),
		.end_x(req.end_x),
		.start_z(req.start_z),
		.phase(req.phase),
		.step_height(step_height_q),
		.tms(tms),
		.vld_out(front_v),
		.item_out(front_item)
	);

	cst_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.divisor(tms),
		.vld_in(front_v),
		.item_in(front_item),
		.vld_out(div_v),
		.item_out(div_item)
	);

	function automatic logic signed [23:0] sat_vel(input logic neg, input logic [DIV_W-1:0] q);
		if (neg)
			return (q > DIV_W'(8388608)) ? -24'sd8388608 : 24'(-$signed({1'b0, q}));
		return (q > DIV_W'(8388607)) ? 24'sd8388607 : 24'(q);
	endfunction

	assign qx = div_item.lane_x.num;
	assign qz = div_item.lane_z.num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.pos_x <= div_item.pos_x;
			rsp.pos_z <= div_item.pos_z;
			rsp.vel_x <= sat_vel(div_item.neg_x, qx);
			rsp.vel_z <= sat_vel(div_item.neg_z, qz);
		end
	end

	assign rsp.valid = out_v_q;

endmodule

// ===== design/cst_checker.sv =====
`timescale 1ns / 1ps

module cst_checker (
	input logic clk,
	input logic arst_n,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [79:0] rsp_payload,
	input logic cfg_ready
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_payload))
		else $error("response changed while stalled");

	a_req_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready == (!rsp_valid || rsp_ready))
		else $error("request ready out of step with response stall");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind cycloid_swing_trajectory cst_checker u_cst_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_payload({rsp.pos_x, rsp.pos_z, rsp.vel_x, rsp.vel_z}),
	.cfg_ready(cfg.ready)
);

// ===== dv/cst_trajectory_checker.sv =====
`timescale 1ns / 1ps

module cst_trajectory_checker import cst_pkg::*; (
	input logic clk,
	input logic arst_n,
	cst_in_if req_ch,
	cst_out_if rsp_ch,
	cst_cfg_if cfg_ch,
	output int errors,
	output int pending
);

	localparam int TABLE_DEPTH = 1024;
	localparam int POS_BITS = 16;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_z;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_z;
	} foot_point_t;

	foot_point_t point_q[$];
	logic [12:0] lift_height;
	logic [13:0] period_ms;

	function automatic longint table_sine(input logic [31:0] turn);
		longint a;
		longint mag;
		longint rad;
		longint rad2;
		longint t;
		longint acc;
		longint q14;
		logic flip;
		a = longint'(signed'(turn));
		if (a > 64'sd1073741824)
			a = 64'sd2147483648 - a;
		else if (a < -64'sd1073741824)
			a = -64'sd2147483648 - a;
		flip = a < 0;
		mag = flip ? -a : a;
		rad = (mag * 64'sd1686629713) >>> 30;
		rad2 = (rad * rad) >>> 30;
		acc = rad;
		t = rad;
		for (int n = 1; n <= 6; n++) begin
			t = ((t * rad2) >>> 30) / longint'((2 * n) * (2 * n + 1));
			acc = (n % 2 == 1) ? acc - t : acc + t;
		end
		if (acc < 0)
			acc = 0;
		q14 = (acc + 32768) >>> 16;
		if (q14 > 16384)
			q14 = 16384;
		return flip ? -q14 : q14;
	endfunction

	function automatic longint round_div(input longint n, input longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic longint clamp_bits(input longint v, input int bits);
		longint hi;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
	endfunction

	function automatic foot_point_t cycloid_point(input logic signed [15:0] sx,
			input logic signed [15:0] ex, input logic signed [15:0] sz, input logic [15:0] ph);
		foot_point_t fp;
		longint k;
		logic [31:0] turn;
		longint sn;
		longint cs;
		longint tms;
		longint dx;
		longint g;
		longint h;
		k = (longint'(ph) * TABLE_DEPTH) >>> 16;
		turn = 32'((k <<< 32) / TABLE_DEPTH);
		sn = table_sine(turn);
		cs = table_sine(turn + 32'h4000_0000);
		h = longint'(lift_height);
		tms = (period_ms == 0) ? 1 : longint'(period_ms);
		dx = longint'(ex) - longint'(sx);
		g = longint'(ph) * 64'sd1073741824 - sn * 64'sd683565276;
		fp.pos_x = 16'(clamp_bits(sx + round_div(dx * g, 64'sd70368744177664), POS_BITS));
		fp.pos_z = 16'(clamp_bits(sz + round_div(h * (16384 - cs), 32768), POS_BITS));
		fp.vel_x = 24'(clamp_bits(round_div(dx * (16384 - cs) * 1000, 16384 * tms), 24));
		fp.vel_z = 24'(clamp_bits(round_div(h * sn * 1000 * 205887,
			64'sd1073741824 * tms), 24));
		return fp;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	assign pending = point_q.size();

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		foot_point_t want;
		if (!arst_n) begin
			lift_height <= 13'd328;
			period_ms <= 14'd250;
			point_q.delete();
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.index == REG_STEP_HEIGHT)
					lift_height <= cfg_ch.data[12:0];
				else
					period_ms <= cfg_ch.data[13:0];
			end
			if (req_ch.valid && req_ch.ready)
				point_q.push_back(cycloid_point(req_ch.start_x, req_ch.end_x,
					req_ch.start_z, req_ch.phase));
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (point_q.size() == 0) begin
					report_mismatch("unexpected beat", 0, 0);
				end else begin
					want = point_q.pop_front();
					if (rsp_ch.pos_x !== want.pos_x)
						report_mismatch("pos_x", rsp_ch.pos_x, want.pos_x);
					if (rsp_ch.pos_z !== want.pos_z)
						report_mismatch("pos_z", rsp_ch.pos_z, want.pos_z);
					if (rsp_ch.vel_x !== want.vel_x)
						report_mismatch("vel_x", rsp_ch.vel_x, want.vel_x);
					if (rsp_ch.vel_z !== want.vel_z)
						report_mismatch("vel_z", rsp_ch.vel_z, want.vel_z);
				end
			end
		end
	end

endmodule

// ===== dv/cycloid_swing_trajectory_tb.sv =====
`timescale 1ns / 1ps

module cycloid_swing_trajectory_tb import cst_pkg::*;;

	logic clk;
	logic arst_n;
	int errors;
	int pending;
	bit calm;
	bit hold_req;
	int hold_left;
	int idle_cycles;

	cst_in_if req();
	cst_out_if rsp();
	cst_cfg_if cfg();

	cycloid_swing_trajectory dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	cst_trajectory_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_ch(req),
		.rsp_ch(rsp),
		.cfg_ch(cfg),
		.errors(errors),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready = 1'b0;
		end else begin
			rsp.ready = calm || ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
				|| (cfg.valid && cfg.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= 20000) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic send_sample(input logic [15:0] sx, input logic [15:0] ex,
			input logic [15:0] sz, input logic [15:0] ph);
		if (!calm && $urandom_range(99) < 6) begin
			req.valid = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		req.valid = 1'b1;
		req.start_x = sx;
		req.end_x = ex;
		req.start_z = sz;
		req.phase = ph;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	task automatic drain();
		req.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic random_sample();
		logic [15:0] sx;
		logic [15:0] ex;
		sx = 16'($urandom);
		case ($urandom_range(3))
			0: ex = 16'($urandom);
			1: ex = sx + 16'($urandom_range(2000)) - 16'd1000;
			2: ex = sx + 16'($urandom_range(600));
			default: ex = {$urandom_range(1) ? 16'h7fff : 16'h8000};
		endcase
		send_sample(sx, ex, 16'($urandom), 16'($urandom));
	endtask

	initial begin
		logic [15:0] heights[8];
		logic [15:0] periods[8];
		arst_n = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		idle_cycles = 0;
		req.valid = 1'b0;
		req.start_x = '0;
		req.end_x = '0;
		req.start_z = '0;
		req.phase = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_STEP_HEIGHT;
		cfg.data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_sample(16'h0000, 16'h1000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h1000, 16'h0000, 16'hffff);
		send_sample(16'h0000, 16'h1000, 16'h0000, 16'h4000);
		send_sample(16'h0000, 16'h1000, 16'h0000, 16'h8000);
		send_sample(16'h0000, 16'h1000, 16'h0000, 16'hc000);
		send_sample(16'h8000, 16'h7fff, 16'h8000, 16'h8000);
		send_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
		send_sample(16'h8000, 16'h8000, 16'h8000, 16'h0000);
		send_sample(16'h8000, 16'h7fff, 16'h7fc0, 16'h2000);
		send_sample(16'h1234, 16'h1234, 16'hedcb, 16'h003f);
		send_sample(16'hffff, 16'h0001, 16'h5555, 16'haaaa);
		drain();

		heights = '{16'd0, 16'd8191, 16'hffff, 16'd8191, 16'd1, 16'd4096, 16'he148, 16'd328};
		periods = '{16'd1, 16'd10000, 16'hc000, 16'd1, 16'd10000, 16'd3, 16'hffff, 16'd250};
		for (int ph_i = 0; ph_i < 8; ph_i++) begin
			write_reg(REG_STEP_HEIGHT, heights[ph_i]);
			write_reg(REG_SWING_PERIOD, periods[ph_i]);
			send_sample(16'h8000, 16'h7fff, 16'h7fff, 16'h4000);
			send_sample(16'h7fff, 16'h8000, 16'h8000, 16'hc000);
			calm = (ph_i == 2);
			for (int n = 0; n < 200; n++) begin
				if (ph_i == 4 && n == 50)
					hold_req = 1'b1;
				random_sample();
			end
			calm = 1'b0;
			drain();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== cycloid_swing_trajectory.f =====
design/cst_pkg.sv
design/cst_if.sv
design/cst_front.sv
design/cst_div.sv
design/cycloid_swing_trajectory.sv
design/cst_checker.sv
dv/cst_trajectory_checker.sv
dv/cycloid_swing_trajectory_tb.sv
